// ===== rtl/detection_track_table_assert.svh =====
`ifndef DETECTION_TRACK_TABLE_ASSERT_SVH
`define DETECTION_TRACK_TABLE_ASSERT_SVH
// assertion helpers for the track table checker
`define DTT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/dtt_pkg.sv =====
`timescale 1ns / 1ps
package dtt_pkg;
   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam int PosW = 20;
   localparam int KindW = 8;
   localparam int ConfW = 24;
   localparam int DistW = 44;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] REG_MATCH = 3'd0;
   localparam logic [2:0] REG_GROWTH = 3'd1;
   localparam logic [2:0] REG_DECAY = 3'd2;
   localparam logic [2:0] REG_THRESH = 3'd3;
   localparam logic [2:0] REG_MAXCONF = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MATCH, ST_APPEND, ST_REPORT, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clr_count;
      logic idx_clear;
      logic idx_step;
      logic upd_match;
      logic upd_tick;
      logic append;
      logic best_clear;
      logic best_valid;
      logic drop_set;
      logic out_load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       idx_last;
      logic       near;
      logic       full;
      logic       empty;
   } sts_type;
endpackage

// ===== rtl/dtt_ctrl.sv =====
`timescale 1ns / 1ps
module dtt_ctrl
   import dtt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output ctl_type ctl
);
   state_type state_ff, state_in;

   // scan: one entry per cycle, read and compared in the same cycle
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.op == OP_ADD) begin
               if (sts.empty) state_in = ST_APPEND;
               else state_in = ST_MATCH;
            end else if (sts.op == OP_TICK && !sts.empty) begin
               state_in = ST_MATCH;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_MATCH: begin
            if (sts.op == OP_ADD && sts.near) state_in = ST_REPORT;
            else if (sts.idx_last) begin
               state_in = (sts.op == OP_ADD) ? ST_APPEND : ST_REPORT;
            end
         end
         ST_APPEND: state_in = ST_REPORT;
         ST_REPORT: begin
            if (sts.empty || sts.idx_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.load = req_tvalid;
            ctl.idx_clear = 1'b1;
         end
         ST_SCAN: begin
            ctl.clr_count = (sts.op == OP_CLEAR);
            ctl.idx_clear = 1'b1;
            ctl.best_clear = 1'b1;
         end
         ST_MATCH: begin
            if (sts.op == OP_ADD) begin
               ctl.upd_match = sts.near;
               ctl.idx_step = !sts.near && !sts.idx_last;
            end else begin
               ctl.upd_tick = 1'b1;
               ctl.idx_step = !sts.idx_last;
            end
            ctl.idx_clear = (sts.op == OP_ADD && sts.near) || sts.idx_last;
         end
         ST_APPEND: begin
            ctl.append = !sts.full;
            ctl.drop_set = sts.full;
            ctl.idx_clear = 1'b1;
         end
         ST_REPORT: begin
            ctl.best_valid = !sts.empty;
            ctl.idx_step = !sts.idx_last;
            ctl.out_load = sts.empty || sts.idx_last;
         end
         ST_OUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/dtt_datapath.sv =====
`timescale 1ns / 1ps
module dtt_datapath
   import dtt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   output sts_type           sts,
   input  logic [1:0]        opcode,
   input  logic [PosW-1:0]   pos_x,
   input  logic [PosW-1:0]   pos_y,
   input  logic [PosW-1:0]   pos_z,
   input  logic [KindW-1:0]  object_kind,
   input  logic [DistW-1:0]  match_dist_sq,
   input  logic [16:0]       growth_step,
   input  logic [16:0]       decay_step,
   input  logic [22:0]       report_threshold,
   input  logic [22:0]       max_confidence,
   output logic              best_found,
   output logic [PosW-1:0]   best_x,
   output logic [PosW-1:0]   best_y,
   output logic [PosW-1:0]   best_z,
   output logic [KindW-1:0]  best_kind,
   output logic [ConfW-1:0]  best_confidence,
   output logic [4:0]        entry_count,
   output logic              dropped
);
   // table in flops, read at one index per cycle
   logic [PosW-1:0]  tx_ff [TableDepth];
   logic [PosW-1:0]  ty_ff [TableDepth];
   logic [PosW-1:0]  tz_ff [TableDepth];
   logic [KindW-1:0] tk_ff [TableDepth];
   logic [ConfW-1:0] tc_ff [TableDepth];

   logic [1:0]       op_ff;
   logic [PosW-1:0]  ix_ff, iy_ff, iz_ff;
   logic [KindW-1:0] ik_ff;
   logic [CntW-1:0]  used_ff;
   logic [IdxW-1:0]  idx_ff;
   logic             drop_ff;
   logic             bf_ff;
   logic [IdxW-1:0]  bi_ff;
   logic [ConfW-1:0] bc_ff;

   logic [PosW-1:0]  cx, cy, cz;
   logic [ConfW-1:0] cc;
   assign cx = tx_ff[idx_ff];
   assign cy = ty_ff[idx_ff];
   assign cz = tz_ff[idx_ff];
   assign cc = tc_ff[idx_ff];

   // squared distance: three 21-bit squares, then a sum
   logic signed [PosW:0] dx, dy, dz;
   logic [PosW:0]        ax, ay, az;
   logic [45:0]          d2;
   assign dx = $signed({cx[PosW-1], cx}) - $signed({ix_ff[PosW-1], ix_ff});
   assign dy = $signed({cy[PosW-1], cy}) - $signed({iy_ff[PosW-1], iy_ff});
   assign dz = $signed({cz[PosW-1], cz}) - $signed({iz_ff[PosW-1], iz_ff});
   assign ax = dx[PosW] ? (PosW+1)'(0) - dx : dx;
   assign ay = dy[PosW] ? (PosW+1)'(0) - dy : dy;
   assign az = dz[PosW] ? (PosW+1)'(0) - dz : dz;
   assign d2 = 46'(ax * ax) + 46'(ay * ay) + 46'(az * az);

   function automatic logic [PosW-1:0] favg(logic [PosW-1:0] a, logic [PosW-1:0] b);
      logic signed [PosW:0] s;
      s = $signed({a[PosW-1], a}) + $signed({b[PosW-1], b});
      return s[PosW:1];
   endfunction

   function automatic logic [ConfW-1:0] sat(logic signed [ConfW+1:0] v);
      logic [ConfW-1:0] r;
      if (v > $signed((ConfW+2)'(24'h7fffff))) r = 24'h7fffff;
      else if (v < -$signed((ConfW+2)'(24'h800000))) r = 24'h800000;
      else r = v[ConfW-1:0];
      return r;
   endfunction

   logic signed [ConfW+1:0] cce;
   assign cce = {{2{cc[ConfW-1]}}, cc};
   logic near, below_max, last;
   assign near = (d2 <= {2'b0, match_dist_sq});
   assign below_max = $signed(cce) < $signed({3'b0, max_confidence});
   assign last = ({1'b0, idx_ff} + 1'b1) >= CntW'(used_ff);

   // current entry is above the report threshold and beats the best so far
   logic hit;
   assign hit = ctl.best_valid && ($signed(cce) > $signed({3'b0, report_threshold}))
                && ($signed(cc) > $signed(bf_ff ? bc_ff : ConfW'(0)));

   assign sts.op = op_ff;
   assign sts.idx_last = last;
   assign sts.near = near;
   assign sts.full = (used_ff >= CntW'(TableDepth));
   assign sts.empty = (used_ff == '0);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff <= opcode;
         ix_ff <= pos_x;
         iy_ff <= pos_y;
         iz_ff <= pos_z;
         ik_ff <= object_kind;
      end
      if (ctl.upd_match && below_max) begin
         tx_ff[idx_ff] <= favg(cx, ix_ff);
         ty_ff[idx_ff] <= favg(cy, iy_ff);
         tz_ff[idx_ff] <= favg(cz, iz_ff);
         tc_ff[idx_ff] <= sat(cce + $signed({9'b0, growth_step}));
      end
      if (ctl.upd_tick) tc_ff[idx_ff] <= sat(cce - $signed({9'b0, decay_step}));
      if (ctl.append) begin
         tx_ff[used_ff[IdxW-1:0]] <= ix_ff;
         ty_ff[used_ff[IdxW-1:0]] <= iy_ff;
         tz_ff[used_ff[IdxW-1:0]] <= iz_ff;
         tk_ff[used_ff[IdxW-1:0]] <= ik_ff;
         tc_ff[used_ff[IdxW-1:0]] <= {7'b0, growth_step};
      end
      if (hit) begin
         bi_ff <= idx_ff;
         bc_ff <= cc;
      end
      // last entry is judged in the same cycle the result is loaded
      if (ctl.out_load) begin
         best_found <= bf_ff | hit;
         if (hit) begin
            best_x <= cx;
            best_y <= cy;
            best_z <= cz;
            best_kind <= tk_ff[idx_ff];
            best_confidence <= cc;
         end else if (bf_ff) begin
            best_x <= tx_ff[bi_ff];
            best_y <= ty_ff[bi_ff];
            best_z <= tz_ff[bi_ff];
            best_kind <= tk_ff[bi_ff];
            best_confidence <= bc_ff;
         end else begin
            best_x <= '0;
            best_y <= '0;
            best_z <= '0;
            best_kind <= '0;
            best_confidence <= '0;
         end
         entry_count <= 5'(used_ff);
         dropped <= drop_ff;
      end
      if (reset) begin
         used_ff <= '0;
         idx_ff <= '0;
         drop_ff <= 1'b0;
         bf_ff <= 1'b0;
      end else begin
         if (ctl.clr_count) used_ff <= '0;
         else if (ctl.append) used_ff <= used_ff + 1'b1;
         if (ctl.idx_clear) idx_ff <= '0;
         else if (ctl.idx_step) idx_ff <= idx_ff + 1'b1;
         if (ctl.load) drop_ff <= 1'b0;
         else if (ctl.drop_set) drop_ff <= 1'b1;
         if (ctl.best_clear) bf_ff <= 1'b0;
         else if (hit) bf_ff <= 1'b1;
      end
   end
endmodule

// ===== rtl/detection_track_table.sv =====
`timescale 1ns / 1ps
// sequence: scan; an add walks to the first near entry, else appends (or drops on a full table);
// a tick walks every entry; then report walks the table and the word is held until taken
// tick and report each walk the table once: one entry per cycle
// throughput: one word at a time; the next request is taken after the response is taken
// reset: synchronous, active high; empties the table and restores register defaults
module detection_track_table
   import dtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0] pos_x[21:2] pos_y[41:22] pos_z[61:42] object_kind[69:62], zero pad
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // best_found[0] best_x[20:1] best_y[40:21] best_z[60:41] best_kind[68:61]
   // best_confidence[92:69] entry_count[97:93] dropped[98], zero pad
   output logic [103:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [43:0] csr_data
);
   // configuration registers
   logic [DistW-1:0] match_ff;
   logic [16:0]      growth_ff, decay_ff;
   logic [22:0]      thresh_ff, maxc_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 44'd250000;
         growth_ff <= 17'd6554;
         decay_ff <= 17'd655;
         thresh_ff <= 23'd32768;
         maxc_ff <= 23'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MATCH: match_ff <= csr_data;
            REG_GROWTH: growth_ff <= csr_data[16:0];
            REG_DECAY: decay_ff <= csr_data[16:0];
            REG_THRESH: thresh_ff <= csr_data[22:0];
            REG_MAXCONF: maxc_ff <= csr_data[22:0];
            default: ;
         endcase
      end
   end

   ctl_type ctl;
   sts_type sts;

   dtt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .ctl(ctl)
   );

   // result word fields
   logic             best_found, dropped;
   logic [PosW-1:0]  best_x, best_y, best_z;
   logic [KindW-1:0] best_kind;
   logic [ConfW-1:0] best_confidence;
   logic [4:0]       entry_count;

   dtt_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .opcode(req_tdata[1:0]), .pos_x(req_tdata[21:2]), .pos_y(req_tdata[41:22]),
      .pos_z(req_tdata[61:42]), .object_kind(req_tdata[69:62]),
      .match_dist_sq(match_ff), .growth_step(growth_ff), .decay_step(decay_ff),
      .report_threshold(thresh_ff), .max_confidence(maxc_ff),
      .best_found(best_found), .best_x(best_x), .best_y(best_y), .best_z(best_z),
      .best_kind(best_kind), .best_confidence(best_confidence),
      .entry_count(entry_count), .dropped(dropped)
   );

   assign rsp_tdata = {5'b0, dropped, entry_count, best_confidence, best_kind,
                       best_z, best_y, best_x, best_found};

   logic [1:0] unused_req;
   assign unused_req = req_tdata[71:70];
endmodule

// ===== rtl/dtt_checker.sv =====
`timescale 1ns / 1ps
`include "detection_track_table_assert.svh"
module dtt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   `DTT_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `DTT_ASSERT_IMPL(a_count_range, clock, reset, rsp_tvalid, rsp_tdata[97:93] <= 5'd16)
   `DTT_ASSERT_IMPL(a_zero_none, clock, reset, rsp_tvalid && !rsp_tdata[0],
                    rsp_tdata[92:1] == '0)
   `DTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
endmodule

bind detection_track_table dtt_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== dv/detection_track_table_checker.sv =====
`timescale 1ns / 1ps
module detection_track_table_checker
   import dtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [43:0] csr_data,
   output int          fail_count
);
   localparam longint ConfHi = 8388607;
   localparam longint ConfLo = -8388608;

   typedef struct {
      logic                     found;
      logic signed [PosW-1:0]   x, y, z;
      logic [KindW-1:0]         kind;
      logic signed [ConfW-1:0]  conf;
      logic [4:0]               count;
      logic                     dropped;
   } track_status_type;

   // tracked table copy
   int trk_x[TableDepth], trk_y[TableDepth], trk_z[TableDepth];
   int trk_kind[TableDepth];
   longint trk_conf[TableDepth];
   int trk_used;

   // register copy
   longint dist_limit, growth, decay, report_min, conf_cap;

   track_status_type status_q[$];

   function automatic longint sat_conf(longint v);
      if (v > ConfHi) return ConfHi;
      if (v < ConfLo) return ConfLo;
      return v;
   endfunction

   function automatic track_status_type track_step(logic [71:0] d);
      track_status_type r;
      int px, py, pz, best_idx, hit;
      longint dx, dy, dz, peak_conf;
      px = int'($signed(d[21:2]));
      py = int'($signed(d[41:22]));
      pz = int'($signed(d[61:42]));
      r = '{default: '0};
      case (d[1:0])
         OP_ADD: begin
            hit = -1;
            for (int i = 0; i < trk_used && hit < 0; i++) begin
               dx = longint'(trk_x[i]) - px;
               dy = longint'(trk_y[i]) - py;
               dz = longint'(trk_z[i]) - pz;
               if (dx * dx + dy * dy + dz * dz <= dist_limit) hit = i;
            end
            if (hit >= 0) begin
               // floor average by arithmetic shift
               if (trk_conf[hit] < conf_cap) begin
                  trk_x[hit] = (trk_x[hit] + px) >>> 1;
                  trk_y[hit] = (trk_y[hit] + py) >>> 1;
                  trk_z[hit] = (trk_z[hit] + pz) >>> 1;
                  trk_conf[hit] = sat_conf(trk_conf[hit] + growth);
               end
            end else if (trk_used >= TableDepth) begin
               r.dropped = 1'b1;
            end else begin
               trk_x[trk_used] = px;
               trk_y[trk_used] = py;
               trk_z[trk_used] = pz;
               trk_kind[trk_used] = int'(d[69:62]);
               trk_conf[trk_used] = sat_conf(growth);
               trk_used++;
            end
         end
         OP_TICK: begin
            for (int i = 0; i < trk_used; i++) trk_conf[i] = sat_conf(trk_conf[i] - decay);
         end
         OP_CLEAR: trk_used = 0;
         default: ;
      endcase
      peak_conf = 0;
      best_idx = -1;
      for (int i = 0; i < trk_used; i++) begin
         if (trk_conf[i] > report_min && trk_conf[i] > peak_conf) begin
            peak_conf = trk_conf[i];
            best_idx = i;
         end
      end
      if (best_idx >= 0) begin
         r.found = 1'b1;
         r.x = PosW'(trk_x[best_idx]);
         r.y = PosW'(trk_y[best_idx]);
         r.z = PosW'(trk_z[best_idx]);
         r.kind = KindW'(trk_kind[best_idx]);
         r.conf = ConfW'(peak_conf);
      end
      r.count = 5'(trk_used);
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, name, want, got);
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      track_status_type want;
      if (reset) begin
         dist_limit = 250000;
         growth = 6554;
         decay = 655;
         report_min = 32768;
         conf_cap = 65536;
         trk_used = 0;
         status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MATCH: dist_limit = longint'(csr_data);
               REG_GROWTH: growth = longint'(csr_data[16:0]);
               REG_DECAY: decay = longint'(csr_data[16:0]);
               REG_THRESH: report_min = longint'(csr_data[22:0]);
               REG_MAXCONF: conf_cap = longint'(csr_data[22:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            status_q.insert(status_q.size(), track_step(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("%0t unexpected word %h", $realtime, rsp_tdata);
            end else begin
               want = status_q.pop_front();
               check_field("best_found", want.found, rsp_tdata[0]);
               check_field("best_x", want.x, $signed(rsp_tdata[20:1]));
               check_field("best_y", want.y, $signed(rsp_tdata[40:21]));
               check_field("best_z", want.z, $signed(rsp_tdata[60:41]));
               check_field("best_kind", want.kind, rsp_tdata[68:61]);
               check_field("best_confidence", want.conf, $signed(rsp_tdata[92:69]));
               check_field("entry_count", want.count, rsp_tdata[97:93]);
               check_field("dropped", want.dropped, rsp_tdata[98]);
               check_field("pad", 0, rsp_tdata[103:99]);
            end
         end
      end
   end
endmodule

// ===== dv/tb_detection_track_table.sv =====
`timescale 1ns / 1ps
module tb_detection_track_table;
   import dtt_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int StallLimit = 3000;   // cycles with no word moving anywhere
   localparam int DrainWait = 45;      // longest add latency plus margin
   localparam int PosMax = 524287;
   localparam int PosMin = -524288;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // opcode, pos_x, pos_y, pos_z, object_kind, zero pad
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // best_found, best_x, best_y, best_z, best_kind, best_confidence, entry_count, dropped
   logic [103:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = REG_MATCH;
   logic [43:0]  csr_data = '0;
   int           fail_count;

   int          words_sent = 0;
   int          words_back = 0;
   int          burst_left = 0;
   logic [31:0] stall_pattern = '1;
   int          stall_pos = 0;
   int          idle_cycles = 0;
   int          ctr_x[6], ctr_y[6], ctr_z[6];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   detection_track_table i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   detection_track_table_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count
   );

   // receiver stalls follow a rotating per-phase pattern
   always @(negedge clock) begin
      rsp_tready <= stall_pattern[stall_pos];
      stall_pos <= (stall_pos + 1) % 32;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) words_back <= words_back + 1;
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one input word, preceded by a random gap at each burst boundary
   task automatic send_word(input logic [1:0] op, input int x, input int y, input int z,
                            input int kind);
      int gap;
      logic [19:0] px, py, pz;
      logic [7:0] pk;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      px = 20'(x);
      py = 20'(y);
      pz = 20'(z);
      pk = 8'(kind);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pk, pz, py, px, op};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      words_sent++;
   endtask

   // drop valid and let every outstanding word come back
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_back != words_sent) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [43:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_pos();
      return int'($urandom_range(0, 20'hFFFFF)) + PosMin;
   endfunction

   function automatic int near_pos(input int c, input int spread);
      int v;
      v = c + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > PosMax) v = PosMax;
      if (v < PosMin) v = PosMin;
      return v;
   endfunction

   // pick an extreme, a default or a random value
   function automatic logic [43:0] pick_value(input logic [43:0] lo, input logic [43:0] hi,
                                             input logic [43:0] dflt);
      case ($urandom_range(0, 4))
         0: return lo;
         1: return hi;
         2: return dflt;
         default: return 44'(lo + ({$urandom, $urandom} % (hi - lo + 44'd1)));
      endcase
   endfunction

   task automatic random_phase(input int n_items);
      int c, spread, r;
      for (int i = 0; i < 6; i++) begin
         ctr_x[i] = rand_pos();
         ctr_y[i] = rand_pos();
         ctr_z[i] = rand_pos();
      end
      spread = $urandom_range(0, 1) ? 300 : 3000;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         c = $urandom_range(0, 5);
         if (r < 55)
            send_word(OP_ADD, near_pos(ctr_x[c], spread), near_pos(ctr_y[c], spread),
                      near_pos(ctr_z[c], spread), $urandom_range(0, 255));
         else if (r < 70)
            send_word(OP_ADD, rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 255));
         else if (r < 92)
            send_word(OP_TICK, rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 255));
         else if (r < 97)
            send_word(OP_CLEAR, rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 255));
         else
            send_word(OP_SPARE, rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 255));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, empty table, spare opcode, extreme positions
      send_word(OP_SPARE, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_ADD, PosMax, PosMax, PosMax, 255);
      send_word(OP_ADD, PosMin, PosMin, PosMin, 0);
      send_word(OP_ADD, PosMax - 3, PosMax - 1, PosMax, 17);
      send_word(OP_ADD, PosMin + 1, PosMin + 3, PosMin, 33);
      send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_CLEAR, 0, 0, 0, 0);
      drain();

      // directed: fast growth so entries get reported, then fill past depth
      write_reg(REG_GROWTH, 44'd65536);
      for (int i = 0; i < TableDepth + 2; i++)
         send_word(OP_ADD, PosMin + i * 60000, -1000 * i, 7 * i, i);
      send_word(OP_ADD, PosMin + 5 * 60000 + 1, -5000, 36, 99);
      send_word(OP_SPARE, 0, 0, 0, 0);
      drain();

      // decay down to the lower saturation limit
      write_reg(REG_DECAY, 44'd65536);
      write_reg(REG_THRESH, 44'd0);
      write_reg(REG_MAXCONF, 44'd4194304);
      write_reg(REG_MATCH, 44'hFFF_FFFF_FFFF);
      for (int i = 0; i < 140; i++) send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_ADD, 12, -12, 5, 3);
      send_word(OP_ADD, 11, -11, 4, 3);
      drain();

      // random phases, register settings and stall patterns change between them
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 3)
            0: stall_pattern = '1;
            1: stall_pattern = $urandom | 32'h1;
            default: stall_pattern = $urandom | $urandom | 32'h1;
         endcase
         write_reg(REG_MATCH, (ph == 0) ? 44'd0 : (ph == 1) ? 44'hFFF_FFFF_FFFF
                   : pick_value(44'd0, 44'd40000000, 44'd250000));
         write_reg(REG_GROWTH, pick_value(44'd0, 44'd65536, 44'd6554));
         write_reg(REG_DECAY, pick_value(44'd0, 44'd65536, 44'd655));
         write_reg(REG_THRESH, pick_value(44'd0, 44'd4194304, 44'd32768));
         write_reg(REG_MAXCONF, pick_value(44'd0, 44'd4194304, 44'd65536));
         random_phase(120);
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
